// ----- src/vxoc_pkg.sv -----
// ----------------------------------------------------------------------------
// vxoc_pkg
// Shared types and constants for the voxel occlusion cull core: command
// codes, the stored entry layout, read step codes, controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package vxoc_pkg;

  localparam int COORD_W = 4;
  localparam int ID_W    = 11;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic            present;
    logic            occludes;
    logic [ID_W-1:0] id;
  } entry_t;

  typedef logic [2:0] step_t;

  localparam step_t STEP_CENTRE = 3'd0;
  localparam step_t STEP_XP     = 3'd1;
  localparam step_t STEP_XM     = 3'd2;
  localparam step_t STEP_YP     = 3'd3;
  localparam step_t STEP_YM     = 3'd4;
  localparam step_t STEP_ZP     = 3'd5;
  localparam step_t STEP_ZM     = 3'd6;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DECIDE
  } state_t;

  typedef struct packed {
    logic  take;
    logic  clr_en;
    logic  rd_en;
    step_t step;
    logic  load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic req_query;
    logic req_inside;
    logic interior;
    logic out_free;
  } ctrl_stat_t;

  function automatic logic blocks_face(input entry_t e);
    return e.present & e.occludes;
  endfunction

endpackage

// ----- src/vxoc_if.sv -----
// ----------------------------------------------------------------------------
// vxoc_in_if / vxoc_out_if
// Valid/ready channels carrying command words into the core and render
// value words out of it.
// ----------------------------------------------------------------------------
interface vxoc_in_if;
  import vxoc_pkg::*;

  logic               valid;
  logic               ready;
  logic               cmd;
  logic [COORD_W-1:0] x_coord;
  logic [COORD_W-1:0] y_coord;
  logic [COORD_W-1:0] z_coord;
  logic               present;
  logic               occludes;
  logic [ID_W-1:0]    render_id;

  modport source (
    output valid, cmd, x_coord, y_coord, z_coord, present, occludes, render_id,
    input  ready
  );
  modport sink (
    input  valid, cmd, x_coord, y_coord, z_coord, present, occludes, render_id,
    output ready
  );
endinterface

interface vxoc_out_if;
  import vxoc_pkg::*;

  logic            valid;
  logic            ready;
  logic [ID_W-1:0] render_value;

  modport source (output valid, render_value, input ready);
  modport sink (input valid, render_value, output ready);
endinterface

// ----- src/vxoc_ctrl.sv -----
// ----------------------------------------------------------------------------
// vxoc_ctrl
// Controller: sequences the clearing sweep after reset, command acceptance,
// the centre and six neighbour reads of a query and the result hand-off.
// ----------------------------------------------------------------------------
module vxoc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  vxoc_pkg::ctrl_stat_t stat,
  output vxoc_pkg::ctrl_cmd_t  cmd
);
  import vxoc_pkg::*;

  state_t state_r, state_nxt;
  step_t  step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      step_r  <= STEP_CENTRE;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      ST_CLEAR: begin
        if (stat.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid && stat.req_query) begin
          state_nxt = stat.req_inside ? ST_READ : ST_DECIDE;
          step_nxt  = STEP_CENTRE;
        end
      end
      ST_READ: begin
        if (step_r == STEP_ZM || !stat.interior) begin
          state_nxt = ST_DECIDE;
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
      ST_DECIDE: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_en = 1'b1;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
        cmd.step  = step_r;
      end
      ST_DECIDE: begin
        cmd.load = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- src/vxoc_datapath.sv -----
// ----------------------------------------------------------------------------
// vxoc_datapath
// Datapath: the single-port voxel store, address generation, the query
// accumulators and the output register.
// ----------------------------------------------------------------------------
module vxoc_datapath #(
  parameter int CHUNK_SIDE = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  vxoc_pkg::ctrl_cmd_t           cmd,
  output vxoc_pkg::ctrl_stat_t          stat,
  input  logic                          in_cmd,
  input  logic [vxoc_pkg::COORD_W-1:0]  in_x_coord,
  input  logic [vxoc_pkg::COORD_W-1:0]  in_y_coord,
  input  logic [vxoc_pkg::COORD_W-1:0]  in_z_coord,
  input  logic                          in_present,
  input  logic                          in_occludes,
  input  logic [vxoc_pkg::ID_W-1:0]     in_render_id,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [vxoc_pkg::ID_W-1:0]     out_render_value
);
  import vxoc_pkg::*;

  localparam int SIDE_SQ = CHUNK_SIDE * CHUNK_SIDE;
  localparam int CELLS   = SIDE_SQ * CHUNK_SIDE;
  localparam int AW      = $clog2(CELLS);
  localparam int CW      = COORD_W + 1;

  function automatic logic [AW-1:0] cell_index(
    input logic [COORD_W-1:0] x,
    input logic [COORD_W-1:0] y,
    input logic [COORD_W-1:0] z
  );
    return AW'(x) + AW'(y) * AW'(CHUNK_SIDE) + AW'(z) * AW'(SIDE_SQ);
  endfunction

  entry_t mem [CELLS];

  logic [AW-1:0]      clr_cnt_r;
  logic [COORD_W-1:0] x_r, y_r, z_r;
  logic               inside_r;
  entry_t             rd_data_r;
  logic               pend_r;
  logic               pend_centre_r;
  entry_t             centre_r;
  logic               blocked_r;
  logic               out_valid_r;
  logic [ID_W-1:0]    value_r;

  logic [COORD_W-1:0] rx, ry, rz;
  logic [AW-1:0]      rd_addr, wr_addr, mem_addr;
  logic               mem_we;
  entry_t             mem_wdata;
  logic               req_inside;
  logic               interior;
  entry_t             eff_centre;
  logic               eff_blocked;
  logic [ID_W-1:0]    value;

  localparam logic [COORD_W-1:0] LAST = COORD_W'(CHUNK_SIDE - 1);

  assign req_inside = ({1'b0, in_x_coord} < CW'(CHUNK_SIDE)) &&
                      ({1'b0, in_y_coord} < CW'(CHUNK_SIDE)) &&
                      ({1'b0, in_z_coord} < CW'(CHUNK_SIDE));

  assign interior = (x_r != '0) && (x_r != LAST) && (y_r != '0) && (y_r != LAST) &&
                    (z_r != '0) && (z_r != LAST);

  always_comb begin
    rx = x_r;
    ry = y_r;
    rz = z_r;
    case (cmd.step)
      STEP_CENTRE: rx = x_r;
      STEP_XP:     rx = x_r + COORD_W'(1);
      STEP_XM:     rx = x_r - COORD_W'(1);
      STEP_YP:     ry = y_r + COORD_W'(1);
      STEP_YM:     ry = y_r - COORD_W'(1);
      STEP_ZP:     rz = z_r + COORD_W'(1);
      STEP_ZM:     rz = z_r - COORD_W'(1);
      default:     rx = x_r;
    endcase
  end

  assign rd_addr = cell_index(rx, ry, rz);
  assign wr_addr = cell_index(in_x_coord, in_y_coord, in_z_coord);

  assign mem_we   = cmd.clr_en || (cmd.take && in_cmd == CMD_WRITE && req_inside);
  assign mem_addr = cmd.clr_en ? clr_cnt_r : (cmd.rd_en ? rd_addr : wr_addr);

  always_comb begin
    mem_wdata = '0;
    if (!cmd.clr_en && in_present) begin
      mem_wdata.present  = 1'b1;
      mem_wdata.occludes = in_occludes;
      mem_wdata.id       = in_render_id;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (cmd.rd_en) rd_data_r <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_en) clr_cnt_r <= clr_cnt_r + AW'(1);
      pend_r <= cmd.rd_en;
      if (cmd.load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_centre_r <= (cmd.step == STEP_CENTRE);
    if (cmd.take) begin
      x_r       <= in_x_coord;
      y_r       <= in_y_coord;
      z_r       <= in_z_coord;
      inside_r  <= req_inside;
      centre_r  <= '0;
      blocked_r <= 1'b1;
    end else if (pend_r) begin
      if (pend_centre_r) begin
        centre_r <= rd_data_r;
      end else begin
        blocked_r <= blocked_r & blocks_face(rd_data_r);
      end
    end
    if (cmd.load) value_r <= value;
  end

  assign eff_centre  = (pend_r && pend_centre_r) ? rd_data_r : centre_r;
  assign eff_blocked = blocked_r &
                       (!(pend_r && !pend_centre_r) || blocks_face(rd_data_r));
  assign value = (inside_r && eff_centre.present && !(interior && eff_blocked)) ?
                 eff_centre.id : '0;

  assign stat.clr_last   = (clr_cnt_r == AW'(CELLS - 1));
  assign stat.req_query  = (in_cmd == CMD_QUERY);
  assign stat.req_inside = req_inside;
  assign stat.interior   = interior;
  assign stat.out_free   = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_render_value = value_r;

endmodule

// ----- src/voxel_occlusion_cull_core.sv -----
// A write word is stored when accepted; a new word is accepted in the next cycle.
// A query reads the single-port voxel store for the centre and its six face
// neighbours, then loads its result in a decide state once the output is free.
// Border voxels read only the centre; out-of-chunk queries go straight to decide.
// After reset the store is swept to absent over all CHUNK_SIDE cubed cells (4096
// at the default side); no word is accepted during the sweep.
// ----------------------------------------------------------------------------
// voxel_occlusion_cull_core
// Top level: a cubic voxel chunk with six-neighbour occlusion culling on query.
// ----------------------------------------------------------------------------
module voxel_occlusion_cull_core #(
  parameter int CHUNK_SIDE = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  vxoc_in_if.sink           in_chan,
  vxoc_out_if.source        out_chan
);
  import vxoc_pkg::*;

  ctrl_cmd_t  cmd_s;
  ctrl_stat_t stat_s;
  logic       in_ready;

  vxoc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .stat     (stat_s),
    .cmd      (cmd_s)
  );

  vxoc_datapath #(
    .CHUNK_SIDE (CHUNK_SIDE)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd_s),
    .stat             (stat_s),
    .in_cmd           (in_chan.cmd),
    .in_x_coord       (in_chan.x_coord),
    .in_y_coord       (in_chan.y_coord),
    .in_z_coord       (in_chan.z_coord),
    .in_present       (in_chan.present),
    .in_occludes      (in_chan.occludes),
    .in_render_id     (in_chan.render_id),
    .out_valid        (out_chan.valid),
    .out_ready        (out_chan.ready),
    .out_render_value (out_chan.render_value)
  );

  assign in_chan.ready = in_ready;

  a_query_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_s.take && in_chan.cmd == CMD_QUERY) |=> !in_chan.ready)
    else $error("Word accepted while a query was in progress.");

  a_load_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_s.load |-> (!out_chan.valid || out_chan.ready))
    else $error("Result loaded over a word not yet taken.");

  a_no_access_during_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_s.clr_en |-> (!in_chan.ready && !cmd_s.rd_en))
    else $error("Store accessed during the clearing sweep.");

endmodule
